// ----- rtl/psf_pkg.sv -----
// psf_pkg: shared types and constants of the planar span fill block
// span command and masked write beats, controller to datapath signal groups
// no dependencies

package psf_pkg;

    localparam int unsigned MAX_WIDTH_PIXELS_DEF = 1024;
    localparam int unsigned ADDRESS_BITS_DEF     = 24;

    localparam int unsigned ROW_W    = 10;
    localparam int unsigned X_W      = 10;
    localparam int unsigned COLOR_W  = 4;
    localparam int unsigned ADDR_W   = 24;
    localparam int unsigned PLANE_W  = 16;
    localparam int unsigned PLANES   = 4;
    localparam int unsigned GROUP_W  = 6;
    localparam int unsigned BIT_W    = 4;
    localparam int unsigned PITCH_W  = 11;
    localparam int unsigned PROD_W   = ROW_W + PITCH_W;
    localparam int unsigned CFG_W    = 24;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 11'd80;
    localparam logic [PLANE_W-1:0] FULL_MASK   = 16'hFFFF;
    localparam logic [BIT_W-1:0]   LAST_BIT    = 4'd15;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_BASE = 1'b0,
        REG_ROW_PITCH  = 1'b1
    } t_reg_index;

    typedef struct packed {
        logic [ROW_W-1:0]   row_y;
        logic [X_W-1:0]     x_start;
        logic [X_W-1:0]     x_end;
        logic [COLOR_W-1:0] color;
    } t_span_cmd;

    typedef struct packed {
        logic [ADDR_W-1:0]         word_address;
        logic [PLANES*PLANE_W-1:0] plane_data;
        logic [PLANE_W-1:0]        bit_mask;
        logic                      last_write;
    } t_span_write;

    typedef struct packed {
        logic load;
        logic mul;
        logic row;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic last_group;
    } t_dp_status;

endpackage

// ----- rtl/psf_ctrl.sv -----
// psf_ctrl: sequencer of the planar span fill block
// steps the datapath through load, multiply, row address and one write per group
// depends on psf_pkg

module psf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  psf_pkg::t_dp_status i_status,
    output psf_pkg::t_dp_cmd    o_cmd,
    output logic                busy,
    output logic                o_strobe
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ROW,
        S_EMIT
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_strobe;

    always_comb begin
        o_cmd      = '0;
        o_cmd.load = (r_state == S_IDLE) && start;
        o_cmd.mul  = (r_state == S_MUL);
        o_cmd.row  = (r_state == S_ROW);
        o_cmd.emit = (r_state == S_EMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_busy   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_MUL;
                        r_busy  <= 1'b1;
                    end
                end
                S_MUL: begin
                    r_state <= S_ROW;
                end
                S_ROW: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_strobe <= 1'b1;
                    if (i_status.last_group) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
            endcase
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;

endmodule

// ----- rtl/psf_datapath.sv -----
// psf_datapath: registers, row address multiplier and mask logic of the span fill
// holds configuration, span state and the output beat register
// depends on psf_pkg

module psf_datapath #(
    parameter int unsigned MAX_WIDTH_PIXELS = psf_pkg::MAX_WIDTH_PIXELS_DEF,
    parameter int unsigned ADDRESS_BITS     = psf_pkg::ADDRESS_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [psf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [psf_pkg::CFG_W-1:0]           i_cfg_data,
    input  psf_pkg::t_span_cmd                  i_cmd,
    input  psf_pkg::t_dp_cmd                    i_ctl,
    output psf_pkg::t_dp_status                 o_status,
    output psf_pkg::t_span_write                o_write
);

    localparam logic [psf_pkg::X_W-1:0] X_MAX = psf_pkg::X_W'(MAX_WIDTH_PIXELS - 1);

    logic [psf_pkg::ADDR_W-1:0]   r_frame_base;
    logic [psf_pkg::PITCH_W-1:0]  r_row_pitch;

    logic [psf_pkg::ROW_W-1:0]    r_row_y;
    logic [psf_pkg::GROUP_W-1:0]  r_group;
    logic [psf_pkg::GROUP_W-1:0]  r_end_group;
    logic [psf_pkg::BIT_W-1:0]    r_left_bit;
    logic [psf_pkg::BIT_W-1:0]    r_right_bit;
    logic [psf_pkg::COLOR_W-1:0]  r_fill_color;
    logic                         r_first;
    logic [psf_pkg::PROD_W-1:0]   r_product;
    logic [ADDRESS_BITS-1:0]      r_row_address;
    psf_pkg::t_span_write         r_write;

    logic [psf_pkg::X_W-1:0]      xa_clamp;
    logic [psf_pkg::X_W-1:0]      xb_clamp;
    logic [psf_pkg::X_W-1:0]      x_lo;
    logic [psf_pkg::X_W-1:0]      x_hi;
    logic                         last_group;
    logic [ADDRESS_BITS-1:0]      group_address;
    logic [psf_pkg::PLANE_W-1:0]  mask;
    logic [psf_pkg::PLANES*psf_pkg::PLANE_W-1:0] data;

    always_comb begin
        xa_clamp = (i_cmd.x_start > X_MAX) ? X_MAX : i_cmd.x_start;
        xb_clamp = (i_cmd.x_end > X_MAX) ? X_MAX : i_cmd.x_end;
        if (xa_clamp > xb_clamp) begin
            x_lo = xb_clamp;
            x_hi = xa_clamp;
        end else begin
            x_lo = xa_clamp;
            x_hi = xb_clamp;
        end
    end

    assign last_group          = (r_group == r_end_group);
    assign o_status.last_group = last_group;

    // plane 0 word of the group, four words per group
    assign group_address = r_row_address + ADDRESS_BITS'({r_group, 2'b00});

    always_comb begin
        mask = psf_pkg::FULL_MASK;
        if (r_first) begin
            mask = mask & (psf_pkg::FULL_MASK >> r_left_bit);
        end
        if (last_group) begin
            mask = mask & (psf_pkg::FULL_MASK << (psf_pkg::LAST_BIT - r_right_bit));
        end
    end

    always_comb begin
        for (int k = 0; k < int'(psf_pkg::PLANES); k++) begin
            data[k*psf_pkg::PLANE_W +: psf_pkg::PLANE_W] = {psf_pkg::PLANE_W{r_fill_color[k]}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_base <= '0;
            r_row_pitch  <= psf_pkg::PITCH_RESET;
        end else if (i_cfg_we) begin
            unique case (psf_pkg::t_reg_index'(i_cfg_index))
                psf_pkg::REG_FRAME_BASE: r_frame_base <= i_cfg_data;
                psf_pkg::REG_ROW_PITCH:  r_row_pitch  <= i_cfg_data[psf_pkg::PITCH_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_y       <= '0;
            r_group       <= '0;
            r_end_group   <= '0;
            r_left_bit    <= '0;
            r_right_bit   <= '0;
            r_fill_color  <= '0;
            r_first       <= 1'b0;
            r_product     <= '0;
            r_row_address <= '0;
            r_write       <= '0;
        end else begin
            if (i_ctl.load) begin
                r_row_y      <= i_cmd.row_y;
                r_group      <= x_lo[psf_pkg::X_W-1 -: psf_pkg::GROUP_W];
                r_end_group  <= x_hi[psf_pkg::X_W-1 -: psf_pkg::GROUP_W];
                r_left_bit   <= x_lo[psf_pkg::BIT_W-1:0];
                r_right_bit  <= x_hi[psf_pkg::BIT_W-1:0];
                r_fill_color <= i_cmd.color;
                r_first      <= 1'b1;
            end
            if (i_ctl.mul) begin
                r_product <= psf_pkg::PROD_W'(r_row_y) * psf_pkg::PROD_W'(r_row_pitch);
            end
            if (i_ctl.row) begin
                r_row_address <= ADDRESS_BITS'(r_frame_base) + ADDRESS_BITS'(r_product);
            end
            if (i_ctl.emit) begin
                r_write.word_address <= psf_pkg::ADDR_W'(group_address);
                r_write.plane_data   <= data;
                r_write.bit_mask     <= mask;
                r_write.last_write   <= last_group;
                r_first              <= 1'b0;
                r_group              <= r_group + psf_pkg::GROUP_W'(1);
            end
        end
    end

    assign o_write = r_write;

endmodule

// ----- rtl/planar_span_fill.sv -----
// planar_span_fill: top level of the four-bitplane horizontal span fill
// joins the sequencer psf_ctrl and the datapath psf_datapath
// depends on psf_pkg
//
//  channel   direction  handshake                 beat
//  command   in         start, busy               i_cmd (row, two x ends, color)
//  write     out        o_strobe, one cycle       o_write (address, planes, mask, last)
//  config    in         i_cfg_we, i_cfg_index     i_cfg_data
//
// a span of n sixteen-pixel groups runs through the accept cycle, the row times
// pitch multiply, the row address add, then one write per cycle from the single
// emit stage, n writes in all.
// busy rises at the accepting edge and falls with the last write; a new command may
// be taken at the edge that ends the cycle its last write is shown.
// reset is synchronous and restores base 0 and pitch 80; the receiver cannot stall.

module planar_span_fill #(
    parameter int unsigned MAX_WIDTH_PIXELS = psf_pkg::MAX_WIDTH_PIXELS_DEF,
    parameter int unsigned ADDRESS_BITS     = psf_pkg::ADDRESS_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  psf_pkg::t_span_cmd            i_cmd,
    output logic                          o_strobe,
    output psf_pkg::t_span_write          o_write,
    input  logic                          i_cfg_we,
    input  logic [psf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [psf_pkg::CFG_W-1:0]     i_cfg_data
);

    psf_pkg::t_dp_cmd    dp_cmd;
    psf_pkg::t_dp_status dp_status;
    logic                ctl_start;

    // commands are only taken while idle
    assign ctl_start = start && !busy;

    psf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (ctl_start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    psf_datapath #(
        .MAX_WIDTH_PIXELS (MAX_WIDTH_PIXELS),
        .ADDRESS_BITS     (ADDRESS_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (i_cmd),
        .i_ctl       (dp_cmd),
        .o_status    (dp_status),
        .o_write     (o_write)
    );

endmodule

// ----- verif/planar_span_fill_tb.sv -----
// planar_span_fill_tb: self-checking bench for the four-bitplane span fill block
// predicts every masked write beat from the span command and the current registers
// depends on psf_pkg and rtl/planar_span_fill.sv

module planar_span_fill_tb;

    localparam int unsigned CMD_W = $bits(psf_pkg::t_span_cmd);
    localparam logic [psf_pkg::X_W-1:0] X_MAX =
        psf_pkg::X_W'(psf_pkg::MAX_WIDTH_PIXELS_DEF - 1);

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    psf_pkg::t_span_cmd            i_cmd = '0;
    logic                          o_strobe;
    psf_pkg::t_span_write          o_write;
    logic                          i_cfg_we = 1'b0;
    logic [psf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [psf_pkg::CFG_W-1:0]     i_cfg_data = '0;

    // register copies kept in step with the block
    logic [psf_pkg::ADDR_W-1:0]  frame_base = '0;
    logic [psf_pkg::PITCH_W-1:0] row_pitch = psf_pkg::PITCH_RESET;

    psf_pkg::t_span_cmd   span_queue[$];
    psf_pkg::t_span_write write_queue[$];
    int unsigned          error_count = 0;
    bit                   steady = 1'b0;

    planar_span_fill dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_strobe   (o_strobe),
        .o_write    (o_write),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // one beat per sixteen-pixel group, left to right
    function automatic void plan_span_writes(psf_pkg::t_span_cmd c);
        logic [psf_pkg::X_W-1:0]                     xa;
        logic [psf_pkg::X_W-1:0]                     xb;
        logic [psf_pkg::X_W-1:0]                     lo_x;
        logic [psf_pkg::X_W-1:0]                     hi_x;
        logic [psf_pkg::GROUP_W-1:0]                 grp;
        logic [psf_pkg::GROUP_W-1:0]                 end_grp;
        logic [psf_pkg::ADDR_W-1:0]                  row_addr;
        logic [psf_pkg::PLANES*psf_pkg::PLANE_W-1:0] fill;
        psf_pkg::t_span_write                        w;
        bit                                          first;
        xa = (c.x_start > X_MAX) ? X_MAX : c.x_start;
        xb = (c.x_end > X_MAX) ? X_MAX : c.x_end;
        lo_x = (xa > xb) ? xb : xa;
        hi_x = (xa > xb) ? xa : xb;
        grp = lo_x[psf_pkg::X_W-1:4];
        end_grp = hi_x[psf_pkg::X_W-1:4];
        row_addr = psf_pkg::ADDR_W'(frame_base + psf_pkg::ADDR_W'(c.row_y)
                                    * psf_pkg::ADDR_W'(row_pitch));
        fill = '0;
        for (int k = 0; k < psf_pkg::PLANES; k++) begin
            if (c.color[k])
                fill[k*psf_pkg::PLANE_W +: psf_pkg::PLANE_W] = psf_pkg::FULL_MASK;
        end
        first = 1'b1;
        forever begin
            w.word_address = psf_pkg::ADDR_W'(row_addr + (psf_pkg::ADDR_W'(grp) << 2));
            w.plane_data = fill;
            w.bit_mask = psf_pkg::FULL_MASK;
            if (first)
                w.bit_mask = w.bit_mask & (psf_pkg::FULL_MASK >> lo_x[3:0]);
            w.last_write = (grp == end_grp);
            if (w.last_write)
                w.bit_mask = w.bit_mask & psf_pkg::PLANE_W'(psf_pkg::FULL_MASK
                                                            << (psf_pkg::LAST_BIT - hi_x[3:0]));
            write_queue.push_back(w);
            if (w.last_write)
                break;
            first = 1'b0;
            grp = grp + psf_pkg::GROUP_W'(1);
        end
    endfunction

    // command driver: holds a beat while busy, idles at random otherwise
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy)
                plan_span_writes(i_cmd);
            if (start && busy) begin
                // hold until accepted
            end else if (span_queue.size() > 0 && (steady || $urandom_range(99) >= 30)) begin
                start <= 1'b1;
                i_cmd <= span_queue.pop_front();
            end else begin
                start <= 1'b0;
                i_cmd <= psf_pkg::t_span_cmd'(CMD_W'({$urandom, $urandom}));
            end
        end
    end

    // write monitor
    always @(posedge i_clk) begin
        psf_pkg::t_span_write exp_w;
        if (i_rst_n && o_strobe) begin
            if (write_queue.size() == 0) begin
                $error("unexpected write beat: address %h mask %h",
                       o_write.word_address, o_write.bit_mask);
                error_count++;
            end else begin
                exp_w = write_queue.pop_front();
                if (o_write.word_address !== exp_w.word_address) begin
                    $error("word_address: expected %h, got %h",
                           exp_w.word_address, o_write.word_address);
                    error_count++;
                end
                if (o_write.plane_data !== exp_w.plane_data) begin
                    $error("plane_data: expected %h, got %h",
                           exp_w.plane_data, o_write.plane_data);
                    error_count++;
                end
                if (o_write.bit_mask !== exp_w.bit_mask) begin
                    $error("bit_mask: expected %h, got %h",
                           exp_w.bit_mask, o_write.bit_mask);
                    error_count++;
                end
                if (o_write.last_write !== exp_w.last_write) begin
                    $error("last_write: expected %b, got %b",
                           exp_w.last_write, o_write.last_write);
                    error_count++;
                end
            end
        end
    end

    task automatic write_reg(psf_pkg::t_reg_index idx, logic [psf_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        if (idx == psf_pkg::REG_FRAME_BASE)
            frame_base = value[psf_pkg::ADDR_W-1:0];
        else
            row_pitch = value[psf_pkg::PITCH_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_span(int y, int xa, int xb, int c);
        psf_pkg::t_span_cmd s;
        s.row_y = psf_pkg::ROW_W'(y);
        s.x_start = psf_pkg::X_W'(xa);
        s.x_end = psf_pkg::X_W'(xb);
        s.color = psf_pkg::COLOR_W'(c);
        span_queue.push_back(s);
    endtask

    // mostly short spans, some between any two points of the row, ends reversed half the time
    task automatic queue_random_spans(int count);
        int xa;
        int xb;
        for (int n = 0; n < count; n++) begin
            xa = $urandom_range(1023);
            if ($urandom_range(99) < 20)
                xb = $urandom_range(1023);
            else
                xb = (xa + $urandom_range(47) > 1023) ? 1023 : xa + $urandom_range(47);
            if ($urandom_range(1))
                queue_span($urandom_range(1023), xb, xa, $urandom_range(15));
            else
                queue_span($urandom_range(1023), xa, xb, $urandom_range(15));
        end
    endtask

    task automatic wait_drained();
        while (span_queue.size() > 0 || start || busy || write_queue.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values, edge cases first
        queue_span(0, 0, 1023, 4'hF);
        queue_span(1, 0, 0, 4'h0);
        queue_span(1023, 1023, 1023, 4'h1);
        queue_span(2, 1000, 5, 4'h2);
        queue_span(3, 17, 30, 4'h4);
        queue_span(4, 15, 16, 4'h8);
        queue_span(5, 16, 31, 4'hA);
        queue_span(6, 31, 16, 4'h5);
        queue_span(7, 'h155, 'h2AA, 4'h3);
        queue_span(8, 'h2AA, 'h155, 4'hC);
        queue_span('h155, 100, 100, 4'h7);
        queue_span('h2AA, 47, 48, 4'hE);
        queue_span(9, 1008, 1023, 4'h6);
        queue_span(10, 1023, 0, 4'h9);
        queue_span(11, 5, 9, 4'hB);
        queue_random_spans(30);
        wait_drained();

        // top of the address space, rows wrap past it
        write_reg(psf_pkg::REG_FRAME_BASE, 24'hFFFFFF);
        write_reg(psf_pkg::REG_ROW_PITCH, 24'd1024);
        queue_span(1023, 0, 1023, 4'hF);
        queue_random_spans(30);
        wait_drained();

        // zero pitch folds every row onto the base
        write_reg(psf_pkg::REG_FRAME_BASE, 24'h000000);
        write_reg(psf_pkg::REG_ROW_PITCH, 24'd0);
        queue_random_spans(30);
        wait_drained();

        // back to back commands with no gaps
        steady = 1'b1;
        write_reg(psf_pkg::REG_FRAME_BASE, psf_pkg::CFG_W'($urandom));
        write_reg(psf_pkg::REG_ROW_PITCH, 24'd1);
        queue_random_spans(30);
        wait_drained();
        steady = 1'b0;

        // widest pitch, junk in the unused data bits
        write_reg(psf_pkg::REG_FRAME_BASE, psf_pkg::CFG_W'($urandom));
        write_reg(psf_pkg::REG_ROW_PITCH, {13'($urandom), 11'h7FF});
        queue_random_spans(30);
        wait_drained();

        write_reg(psf_pkg::REG_ROW_PITCH, {13'($urandom), 11'($urandom_range(1024, 1))});
        write_reg(psf_pkg::REG_FRAME_BASE, psf_pkg::CFG_W'($urandom));
        queue_random_spans(30);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (error_count == 0 && write_queue.size() == 0)
            $display("[planar_span_fill] OK");
        else
            $display("[planar_span_fill] ERROR");
        $finish;
    end

    initial begin
        #3000000;
        $display("[planar_span_fill] ERROR");
        $finish;
    end

endmodule

// ----- planar_span_fill.f -----
rtl/psf_pkg.sv
rtl/psf_ctrl.sv
rtl/psf_datapath.sv
rtl/planar_span_fill.sv
verif/planar_span_fill_tb.sv
